@@ hdl/sta_pkg.sv @@
// shared types, scancode constants and translation tables for the scancode to ascii block
package sta_pkg;

   // default ring depth; the ring holds one entry less than this
   localparam int STA_DEPTH = 256;

   // op selector values carried in req_tuser
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_READ = 1'b1;

   // special set-1 scancodes
   localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] SC_CAPS         = 8'h3A;

   // number of make codes that have a table entry
   localparam int TABLE_SIZE = 58;

   // lowercase letter bounds in 7-bit ascii
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;

   // command passed from the front end to the fifo back end
   typedef struct packed {
      logic       is_read;
      logic [6:0] ch;
   } cmd_type;

   // unshifted key map
   localparam logic [6:0] PLAIN_MAP [0:TABLE_SIZE-1] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   // shifted key map
   localparam logic [6:0] UPPER_MAP [0:TABLE_SIZE-1] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

endpackage

@@ hdl/sta_ram.sv @@
// generic simple dual port ram with registered read
module sta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sta_front.sv @@
// front end: accepts beats, tracks shift and caps lock, translates make codes
module sta_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] scan_code
   input  logic             req_tuser,   // [0] op
   output logic             cmd_valid,
   output sta_pkg::cmd_type cmd,
   input  logic             cmd_ready
);
   import sta_pkg::*;

   logic       shift_ff, shift_in;
   logic       caps_ff, caps_in;
   logic       accept;
   logic       is_scan;
   logic       in_table;
   logic       special;
   logic [5:0] tbl_idx;
   logic [6:0] base_ch;
   logic [6:0] upper_ch;
   logic       take_shifted;
   logic [6:0] xlat_ch;

   assign req_tready = cmd_ready;
   assign accept     = req_tvalid && req_tready;
   assign is_scan    = (req_tuser == OP_SCAN);

   // modifier key decode
   always_comb begin
      shift_in = shift_ff;
      caps_in  = caps_ff;
      special  = 1'b1;
      unique case (req_tdata) inside
         SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   shift_in = 1'b1;
         SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_in = 1'b0;
         SC_CAPS:                          caps_in  = ~caps_ff;
         default:                          special  = 1'b0;
      endcase
   end

   // table lookup; caps lock flips the shift only for letters
   assign in_table     = (req_tdata < 8'(TABLE_SIZE)) && !special;
   assign tbl_idx      = req_tdata[5:0];
   assign base_ch      = in_table ? PLAIN_MAP[tbl_idx] : 7'd0;
   assign upper_ch     = in_table ? UPPER_MAP[tbl_idx] : 7'd0;
   assign take_shifted = shift_ff ^ (caps_ff && base_ch >= CHAR_LOWER_A
                                             && base_ch <= CHAR_LOWER_Z);
   assign xlat_ch      = take_shifted ? upper_ch : base_ch;

   // command to the queue: every read, and every push of a nonzero character
   always_comb begin
      cmd.is_read = !is_scan;
      cmd.ch      = is_scan ? xlat_ch : 7'd0;
      cmd_valid   = req_tvalid && (!is_scan || xlat_ch != 7'd0);
   end

   // modifier state
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
      end else if (accept && is_scan) begin
         shift_ff <= shift_in;
         caps_ff  <= caps_in;
      end
   end

endmodule

@@ hdl/sta_cmdq.sv @@
// two-entry command queue between front end and back end
module sta_cmdq (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  sta_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output sta_pkg::cmd_type out_cmd
);
   import sta_pkg::*;

   cmd_type    slot_ff [0:1];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

@@ hdl/sta_back.sv @@
// back end: character ring fifo with push, pop and registered result beat
module sta_back #(
   parameter int DEPTH = sta_pkg::STA_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  sta_pkg::cmd_type cmd,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [6:0] character, [7] zero
   output logic             rsp_tuser    // [0] fifo_empty
);
   import sta_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [AW-1:0] wr_next, rd_next;
   logic          empty, full;
   logic          out_free;
   logic          push_fire, read_fire, pop_fire;
   logic          valid_ff;
   logic          empty_ff;
   logic [6:0]    ram_rd_data;

   // ring status
   assign wr_next = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign empty   = (rd_ptr_ff == wr_ptr_ff);
   assign full    = (wr_next == rd_ptr_ff);

   // a read waits for the output register; a push never waits
   assign out_free  = !valid_ff || rsp_tready;
   assign push_fire = cmd_valid && !cmd.is_read;
   assign read_fire = cmd_valid && cmd.is_read && out_free;
   assign pop_fire  = read_fire && !empty;
   assign cmd_ready = !cmd.is_read || out_free;

   sta_ram #(
      .WIDTH (7),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push_fire && !full),
      .wr_addr (wr_ptr_ff),
      .wr_data (cmd.ch),
      .rd_en   (pop_fire),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // ring pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push_fire && !full) begin
            wr_ptr_ff <= wr_next;
         end
         if (pop_fire) begin
            rd_ptr_ff <= rd_next;
         end
      end
   end

   // result register; character comes straight from the ram output
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= read_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (read_fire) begin
         empty_ff <= empty;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, (empty_ff ? 7'd0 : ram_rd_data)};
   assign rsp_tuser  = empty_ff;

   // a read always yields a result beat in the next cycle
   a_read_gives_beat: assert property (@(posedge clock) disable iff (reset)
      read_fire |=> rsp_tvalid)
      else $error("read did not produce a result beat");

   // a stalled result keeps its character while the ram output is held
   a_stall_holds_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a push into a full ring is dropped
   a_full_drops: assert property (@(posedge clock) disable iff (reset)
      push_fire && full |=> $stable(wr_ptr_ff))
      else $error("push into full ring moved the write pointer");

   // a pop from a non-empty ring advances the read pointer
   a_pop_advances: assert property (@(posedge clock) disable iff (reset)
      pop_fire |=> rd_ptr_ff != $past(rd_ptr_ff))
      else $error("pop did not advance the read pointer");

endmodule

@@ hdl/scancode_to_ascii_fifo_core.sv @@
// top level of the set-1 scancode to ascii translator with character fifo
// Each req beat is either a set-1 scancode (tuser 0) or a read request (tuser 1). Scancodes
// update shift and caps lock or are translated and pushed into a ring fifo of DEPTH-1
// characters; a push into a full fifo is dropped, and scancodes give no rsp beat. Each read
// gives one rsp beat with the popped character, or character 0 with fifo_empty set. One beat
// is accepted every cycle while the command queue has room: the front end translates in the
// accept cycle and hands pushes and reads to a two-entry command queue; the back end retires
// one command per cycle, a read only while the result register is free, against a ram with
// one write and one registered read port. A read passes the queue slot and result register;
// a stalled rsp side holds reads in the queue while scancodes flow on until the queue fills.
module scancode_to_ascii_fifo_core #(
   parameter int DEPTH = sta_pkg::STA_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] scan_code
   input  logic       req_tuser,   // [0] op
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] character, [7] zero
   output logic       rsp_tuser    // [0] fifo_empty
);
   import sta_pkg::*;

   logic    f_valid, f_ready;
   cmd_type f_cmd;
   logic    b_valid, b_ready;
   cmd_type b_cmd;

   // translate and classify
   sta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (f_valid),
      .cmd        (f_cmd),
      .cmd_ready  (f_ready)
   );

   // decoupling queue
   sta_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_cmd   (b_cmd)
   );

   // character fifo
   sta_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (b_valid),
      .cmd_ready  (b_ready),
      .cmd        (b_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
